// File: rtl/lifo_stack_allocator_defines.svh
// ----------------------------------------------------------------------------
// lifo_stack_allocator_defines
// assertion macros shared by the allocator modules
// ----------------------------------------------------------------------------
`ifndef LIFO_STACK_ALLOCATOR_DEFINES_SVH
`define LIFO_STACK_ALLOCATOR_DEFINES_SVH

`ifndef SYNTHESIS

`define LSA_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("lsa assertion failed");

`define LSA_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("lsa assertion failed");

`else

`define LSA_ASSERT_SAME(label, ante, cons)

`define LSA_ASSERT_NEXT(label, ante, cons)

`endif

`endif

// File: rtl/lsa_pkg.sv
// ----------------------------------------------------------------------------
// lsa_pkg
// types and constants of the lifo stack allocator
// ----------------------------------------------------------------------------
package lsa_pkg;

  localparam int FIELD_W = 32;
  localparam int STATUS_W = 3;
  localparam int LIVE_W = 7;

  typedef enum logic [1:0] {
    CMD_ALLOC     = 2'd0,
    CMD_RESIZE    = 2'd1,
    CMD_SET_LIMIT = 2'd2,
    CMD_NOP       = 2'd3
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 3'd0,
    ST_NO_SPACE  = 3'd1,
    ST_NOT_TOP   = 3'd2,
    ST_BAD_META  = 3'd3,
    ST_ZERO_SIZE = 3'd4,
    ST_NO_HEAP   = 3'd5
  } status_t;

  typedef enum logic {
    REG_HEAP_BASE = 1'b0,
    REG_RAM_LIMIT = 1'b1
  } reg_idx_t;

  typedef struct packed {
    cmd_t               command;
    logic [FIELD_W-1:0] address;
    logic [FIELD_W-1:0] size_bytes;
  } in_t;

  typedef struct packed {
    logic [FIELD_W-1:0] result_address;
    status_t            status;
    logic [FIELD_W-1:0] heap_limit_now;
    logic [LIVE_W-1:0]  live_allocations;
    logic [FIELD_W-1:0] bytes_used;
  } out_t;

  typedef struct packed {
    logic [FIELD_W-1:0] heap_base;
    logic [FIELD_W-1:0] ram_limit;
  } cfg_t;

  typedef struct packed {
    logic accept;
    logic prep;
    logic sum;
    logic commit;
  } ctrl_cmd_t;

  typedef struct packed {
    logic out_stall;
  } dp_sts_t;

endpackage

// File: rtl/lifo_stack_allocator.sv
// ----------------------------------------------------------------------------
// lifo_stack_allocator
// last-in-first-out bump allocator with an internal metadata stack
// ----------------------------------------------------------------------------
// Requests are taken one at a time: a request is accepted when in_ready is
// high, which is the case whenever no earlier request is still being worked
// on, and its result is loaded into the output register in the commit state,
// after the prepare and sum states, so a new request is not taken before the
// last one has committed. The work is split into steps: the registered read
// of the metadata stack at acceptance, the size rounding in prepare, the block
// end sum in sum and the limit compare in commit. A result that is not taken
// holds the next request in its commit state until the output register
// frees. The metadata stack needs no clearing after reset, so the block is
// ready straight out of reset. The configuration registers heap_base and
// ram_limit sit at byte addresses 0 and 4 and must be written only while the
// block is idle.
module lifo_stack_allocator import lsa_pkg::*; #(
  parameter int MAX_ALLOCS = 64,
  parameter int PTR_BYTES  = 8,
  parameter int ADDR_WIDTH = 32
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  in_t                in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output out_t               out_data,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [FIELD_W-1:0] pwdata,
  output logic [FIELD_W-1:0] prdata,
  output logic               pready
);

  cfg_t      cfg;
  ctrl_cmd_t cmd;
  dp_sts_t   sts;

  lsa_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  lsa_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  lsa_dp #(
    .MAX_ALLOCS (MAX_ALLOCS),
    .PTR_BYTES  (PTR_BYTES),
    .ADDR_WIDTH (ADDR_WIDTH)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .in_data   (in_data),
    .cfg       (cfg),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

// File: rtl/lsa_ram.sv
// ----------------------------------------------------------------------------
// lsa_ram
// generic single write port ram with registered read
// ----------------------------------------------------------------------------
module lsa_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64,
  localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [IW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [IW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// File: rtl/lsa_regs.sv
// ----------------------------------------------------------------------------
// lsa_regs
// apb configuration registers: heap base and ram limit
// ----------------------------------------------------------------------------
module lsa_regs import lsa_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [FIELD_W-1:0] pwdata,
  output logic [FIELD_W-1:0] prdata,
  output logic               pready,
  output cfg_t               cfg
);

  logic [FIELD_W-1:0] heap_base_r;
  logic [FIELD_W-1:0] ram_limit_r;
  reg_idx_t           idx;
  logic               wr_en;

  assign idx    = reg_idx_t'(paddr[2]);
  assign wr_en  = psel && penable && pwrite && pready;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      heap_base_r <= '0;
      ram_limit_r <= '0;
    end else if (wr_en) begin
      unique case (idx)
        REG_HEAP_BASE: heap_base_r <= pwdata;
        REG_RAM_LIMIT: ram_limit_r <= pwdata;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_HEAP_BASE: prdata = heap_base_r;
      REG_RAM_LIMIT: prdata = ram_limit_r;
    endcase
  end

  assign cfg.heap_base = heap_base_r;
  assign cfg.ram_limit = ram_limit_r;

endmodule

// File: rtl/lsa_ctrl.sv
// ----------------------------------------------------------------------------
// lsa_ctrl
// request sequencer: accept, prepare, sum, commit
// ----------------------------------------------------------------------------
`include "lifo_stack_allocator_defines.svh"

module lsa_ctrl import lsa_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  dp_sts_t   sts,
  output ctrl_cmd_t cmd
);

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_PREP   = 4'b0010,
    S_SUM    = 4'b0100,
    S_COMMIT = 4'b1000
  } state_t;

  state_t state_r;
  state_t state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_nxt  = S_PREP;
        end
      end
      S_PREP: begin
        cmd.prep  = 1'b1;
        state_nxt = S_SUM;
      end
      S_SUM: begin
        cmd.sum   = 1'b1;
        state_nxt = S_COMMIT;
      end
      S_COMMIT: begin
        if (!sts.out_stall) begin
          cmd.commit = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_ready = (state_r == S_IDLE);

  `LSA_ASSERT_NEXT(a_commit_returns_idle, cmd.commit, state_r == S_IDLE)
  `LSA_ASSERT_NEXT(a_accept_starts_prep, cmd.accept, cmd.prep)

endmodule

// File: rtl/lsa_dp.sv
// ----------------------------------------------------------------------------
// lsa_dp
// allocator datapath: pointers, metadata stack, sums and result register
// ----------------------------------------------------------------------------
`include "lifo_stack_allocator_defines.svh"

module lsa_dp import lsa_pkg::*; #(
  parameter int MAX_ALLOCS = 64,
  parameter int PTR_BYTES  = 8,
  parameter int ADDR_WIDTH = 32
) (
  input  logic      clk,
  input  logic      rst_n,
  input  ctrl_cmd_t cmd,
  output dp_sts_t   sts,
  input  in_t       in_data,
  input  cfg_t      cfg,
  output logic      out_valid,
  input  logic      out_ready,
  output out_t      out_data
);

  localparam int AW    = ADDR_WIDTH;
  localparam int SW    = ((AW > FIELD_W) ? AW : FIELD_W) + 2;
  localparam int CW    = $clog2(MAX_ALLOCS + 1);
  localparam int IW    = (MAX_ALLOCS > 1) ? $clog2(MAX_ALLOCS) : 1;
  localparam int CNT_W = $clog2(PTR_BYTES);
  localparam logic [AW-1:0] CNT_MASK = AW'(PTR_BYTES - 1);
  localparam logic [CW-1:0] MAX_C    = CW'(MAX_ALLOCS);

  // request and allocator state
  in_t           req_r;
  logic          started_r;
  logic [AW-1:0] top_end_r;
  logic [AW-1:0] used_r;
  logic [CW-1:0] live_r;
  logic [AW-1:0] limit_r;

  // prepare stage
  logic          nh_r;
  logic [AW-1:0] aligned_r;
  logic          align_ovf_r;
  logic [AW-1:0] start_r;
  logic [AW-1:0] last_r;
  logic          cnt_ok_r;

  // sum stage
  logic [AW-1:0] end_r;
  logic          end_ovf_r;
  logic          cons_ok_r;
  logic          hit_r;

  out_t          out_r;
  logic          out_valid_r;

  logic [AW-1:0] hb;
  logic [AW-1:0] rl;
  logic [AW-1:0] addr_aw;
  logic [AW-1:0] meta;
  logic [AW-1:0] off;
  logic [SW-1:0] lo_sum;
  logic [SW-1:0] al_sum;
  logic [SW-1:0] end_sum;
  logic [AW-1:0] base;
  logic [CW-1:0] live_inc;
  logic [CW-1:0] live_dec;
  logic          ram_we;
  logic [AW-1:0] ram_wdata;

  logic          nh_nxt;
  logic [AW-1:0] aligned_nxt;
  logic          align_ovf_nxt;
  logic [AW-1:0] start_nxt;
  logic [AW-1:0] last_nxt;
  logic          cnt_ok_nxt;
  logic [AW-1:0] end_nxt;
  logic          end_ovf_nxt;
  logic          cons_ok_nxt;
  logic          hit_nxt;

  logic          space_ok;
  logic          full;
  logic [AW-1:0] used_end;
  logic [AW-1:0] top_end_nxt;
  logic [AW-1:0] used_nxt;
  logic [CW-1:0] live_nxt;
  logic [AW-1:0] limit_nxt;
  logic [AW-1:0] res;
  status_t       status;
  out_t          out_nxt;

  assign hb      = AW'(cfg.heap_base);
  assign rl      = AW'(cfg.ram_limit);
  assign addr_aw = AW'(req_r.address);

  assign live_inc = live_r + CW'(1);
  assign live_dec = live_r - CW'(1);

  assign ram_wdata = used_r | AW'(CNT_W'(live_inc));

  lsa_ram #(
    .WIDTH (AW),
    .DEPTH (MAX_ALLOCS)
  ) u_meta (
    .clk   (clk),
    .we    (ram_we && cmd.commit),
    .waddr (live_r[IW-1:0]),
    .wdata (ram_wdata),
    .re    (cmd.accept),
    .raddr (live_dec[IW-1:0]),
    .rdata (meta)
  );

  // prepare: heap check, size rounding, top entry decode
  always_comb begin
    lo_sum        = SW'(hb) + SW'(PTR_BYTES);
    nh_nxt        = ((lo_sum >> AW) != '0) || (lo_sum[AW-1:0] >= rl);
    al_sum        = SW'(req_r.size_bytes) + SW'(PTR_BYTES - 1);
    align_ovf_nxt = (al_sum >> AW) != '0;
    aligned_nxt   = al_sum[AW-1:0] & ~CNT_MASK;
    off           = meta & ~CNT_MASK;
    start_nxt     = hb + off;
    last_nxt      = used_r - off;
    cnt_ok_nxt    = meta[CNT_W-1:0] == CNT_W'(live_r);
  end

  // sum: new block end including the metadata word
  always_comb begin
    base        = (req_r.command == CMD_ALLOC) ? top_end_r : start_r;
    end_sum     = SW'(base) + SW'(aligned_r) + SW'(PTR_BYTES);
    end_ovf_nxt = align_ovf_r || ((end_sum >> AW) != '0);
    end_nxt     = end_sum[AW-1:0];
    cons_ok_nxt = last_r == (top_end_r - start_r);
    hit_nxt     = addr_aw == start_r;
  end

  // commit: decide and update
  always_comb begin
    space_ok    = !end_ovf_r && (end_r <= limit_r);
    full        = live_r >= MAX_C;
    used_end    = end_r - hb;
    top_end_nxt = top_end_r;
    used_nxt    = used_r;
    live_nxt    = live_r;
    limit_nxt   = limit_r;
    ram_we      = 1'b0;
    res         = '0;
    status      = ST_OK;
    unique case (req_r.command)
      CMD_ALLOC: begin
        priority if (nh_r) begin
          status = ST_NO_HEAP;
        end else if (req_r.size_bytes == '0) begin
          status = ST_ZERO_SIZE;
        end else if (!space_ok || full) begin
          status = ST_NO_SPACE;
        end else begin
          ram_we      = 1'b1;
          live_nxt    = live_inc;
          res         = top_end_r;
          top_end_nxt = end_r;
          used_nxt    = used_end;
        end
      end
      CMD_RESIZE: begin
        priority if (nh_r) begin
          status = ST_NO_HEAP;
        end else if ((live_r == '0) || (live_r > MAX_C)) begin
          status = ST_BAD_META;
        end else if (!cnt_ok_r || !cons_ok_r) begin
          status = ST_BAD_META;
        end else if (!hit_r) begin
          status = ST_NOT_TOP;
        end else if (req_r.size_bytes != '0) begin
          if (!space_ok) begin
            status = ST_NO_SPACE;
          end else begin
            res         = start_r;
            top_end_nxt = end_r;
            used_nxt    = used_end;
          end
        end else begin
          top_end_nxt = start_r;
          used_nxt    = used_r - last_r;
          live_nxt    = live_dec;
        end
      end
      CMD_SET_LIMIT: begin
        if ((addr_aw <= rl) && (addr_aw > top_end_r)) begin
          limit_nxt = addr_aw;
        end
      end
      CMD_NOP: begin
      end
    endcase
    out_nxt.result_address   = FIELD_W'(res);
    out_nxt.status           = status;
    out_nxt.heap_limit_now   = FIELD_W'(limit_nxt);
    out_nxt.live_allocations = LIVE_W'(live_nxt);
    out_nxt.bytes_used       = FIELD_W'(used_nxt);
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      req_r <= in_data;
    end
    if (cmd.prep) begin
      nh_r        <= nh_nxt;
      aligned_r   <= aligned_nxt;
      align_ovf_r <= align_ovf_nxt;
      start_r     <= start_nxt;
      last_r      <= last_nxt;
      cnt_ok_r    <= cnt_ok_nxt;
    end
    if (cmd.sum) begin
      end_r     <= end_nxt;
      end_ovf_r <= end_ovf_nxt;
      cons_ok_r <= cons_ok_nxt;
      hit_r     <= hit_nxt;
    end
    if (cmd.commit) begin
      out_r <= out_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      started_r   <= 1'b0;
      top_end_r   <= '0;
      used_r      <= '0;
      live_r      <= '0;
      limit_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      // first request picks up the configured window
      if (cmd.accept && !started_r) begin
        started_r <= 1'b1;
        top_end_r <= hb;
        limit_r   <= rl;
      end
      if (cmd.commit) begin
        top_end_r <= top_end_nxt;
        used_r    <= used_nxt;
        live_r    <= live_nxt;
        limit_r   <= limit_nxt;
      end
      if (cmd.commit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign sts.out_stall = out_valid_r && !out_ready;
  assign out_valid     = out_valid_r;
  assign out_data      = out_r;

  `LSA_ASSERT_SAME(a_no_result_overwrite, cmd.commit, !sts.out_stall)
  `LSA_ASSERT_SAME(a_push_in_range, ram_we && cmd.commit, live_r < MAX_C)
  `LSA_ASSERT_NEXT(a_started_sticky, started_r, started_r)

endmodule
